// ===== rtl/core/quaternion_vector_rotation_top_defines.svh =====
// Assertion macros for the quaternion rotation core.
// Used by modules that hold concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef QUATERNION_VECTOR_ROTATION_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_TOP_DEFINES_SVH

// Implication check, disabled while reset is asserted.
`define QVR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check on the cycle after reset is seen low.
`define QVR_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/qvr_pkg.sv =====
// Shared types and constants for the quaternion rotation pipeline.
// No dependencies; every module of the core imports this package.
package qvr_pkg;

    // Component width and the widths that follow from it.
    localparam int COMP_W = 16;
    localparam int PROD_W = 2 * COMP_W;
    localparam int COEF_W = 2 * COMP_W + 2;
    localparam int MUL_W  = COEF_W + COMP_W;
    localparam int SUM_W  = MUL_W + 2;
    localparam int FRAC_W = 2 * COMP_W - 2;
    localparam int RND_W  = SUM_W - FRAC_W;

    localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    // Rotation direction codes.
    localparam logic REQ_CONJ_FIRST = 1'b0;
    localparam logic REQ_CONJ_LAST  = 1'b1;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef struct packed {
        logic                      req_type;
        logic signed [COMP_W-1:0]  q_w;
        logic signed [COMP_W-1:0]  q_x;
        logic signed [COMP_W-1:0]  q_y;
        logic signed [COMP_W-1:0]  q_z;
        logic signed [COMP_W-1:0]  v_x;
        logic signed [COMP_W-1:0]  v_y;
        logic signed [COMP_W-1:0]  v_z;
    } t_in_word;

    typedef struct packed {
        logic signed [COMP_W-1:0]  r_x;
        logic signed [COMP_W-1:0]  r_y;
        logic signed [COMP_W-1:0]  r_z;
        logic                      saturated;
    } t_out_word;

endpackage

// ===== rtl/core/qvr_coef.sv =====
// Stages one and two: quaternion pair products, then the 3x3 rotation matrix.
// Depends on qvr_pkg.
module qvr_coef (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  qvr_pkg::t_in_word  i_word,
    output logic               o_valid,
    output qvr_pkg::t_coef     o_k [3][3],
    output qvr_pkg::t_comp     o_v [3]
);
    import qvr_pkg::*;

    // Stage one registers.
    logic  r_vld1;
    logic  r_type1;
    t_prod r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_comp r_v1 [3];

    // Stage two registers.
    logic  r_vld2;
    t_coef r_k [3][3];
    t_comp r_v2 [3];

    t_coef n_k [3][3];
    t_coef c_ww, c_xx, c_yy, c_zz, c_xy, c_xz, c_yz, c_swx, c_swy, c_swz;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    // Ten products of quaternion components, each a Q2.30 value.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_type1 <= i_word.req_type;
            r_ww    <= PROD_W'(i_word.q_w) * PROD_W'(i_word.q_w);
            r_xx    <= PROD_W'(i_word.q_x) * PROD_W'(i_word.q_x);
            r_yy    <= PROD_W'(i_word.q_y) * PROD_W'(i_word.q_y);
            r_zz    <= PROD_W'(i_word.q_z) * PROD_W'(i_word.q_z);
            r_xy    <= PROD_W'(i_word.q_x) * PROD_W'(i_word.q_y);
            r_xz    <= PROD_W'(i_word.q_x) * PROD_W'(i_word.q_z);
            r_yz    <= PROD_W'(i_word.q_y) * PROD_W'(i_word.q_z);
            r_wx    <= PROD_W'(i_word.q_w) * PROD_W'(i_word.q_x);
            r_wy    <= PROD_W'(i_word.q_w) * PROD_W'(i_word.q_y);
            r_wz    <= PROD_W'(i_word.q_w) * PROD_W'(i_word.q_z);
            r_v1[0] <= i_word.v_x;
            r_v1[1] <= i_word.v_y;
            r_v1[2] <= i_word.v_z;
        end
    end

    // Widen the products; the w terms take the sign of the rotation direction.
    always_comb begin
        c_ww = COEF_W'(r_ww);
        c_xx = COEF_W'(r_xx);
        c_yy = COEF_W'(r_yy);
        c_zz = COEF_W'(r_zz);
        c_xy = COEF_W'(r_xy);
        c_xz = COEF_W'(r_xz);
        c_yz = COEF_W'(r_yz);
        if (r_type1 == REQ_CONJ_LAST) begin
            c_swx = COEF_W'(r_wx);
            c_swy = COEF_W'(r_wy);
            c_swz = COEF_W'(r_wz);
        end else begin
            c_swx = -COEF_W'(r_wx);
            c_swy = -COEF_W'(r_wy);
            c_swz = -COEF_W'(r_wz);
        end
    end

    // Rotation matrix entries, rows are output components.
    always_comb begin
        n_k[0][0] = c_ww + c_xx - c_yy - c_zz;
        n_k[0][1] = (c_xy - c_swz) <<< 1;
        n_k[0][2] = (c_xz + c_swy) <<< 1;
        n_k[1][0] = (c_xy + c_swz) <<< 1;
        n_k[1][1] = c_ww - c_xx + c_yy - c_zz;
        n_k[1][2] = (c_yz - c_swx) <<< 1;
        n_k[2][0] = (c_xz - c_swy) <<< 1;
        n_k[2][1] = (c_yz + c_swx) <<< 1;
        n_k[2][2] = c_ww - c_xx - c_yy + c_zz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_v2[i] <= r_v1[i];
                for (int j = 0; j < 3; j++) begin
                    r_k[i][j] <= n_k[i][j];
                end
            end
        end
    end

    assign o_valid = r_vld2;
    assign o_k     = r_k;
    assign o_v     = r_v2;

endmodule

// ===== rtl/core/qvr_mac.sv =====
// Stages three and four: matrix times vector, then row sums with the rounding half.
// Depends on qvr_pkg.
module qvr_mac (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  qvr_pkg::t_coef  i_k [3][3],
    input  qvr_pkg::t_comp  i_v [3],
    output logic            o_valid,
    output qvr_pkg::t_sum   o_sum [3]
);
    import qvr_pkg::*;

    localparam t_sum HALF = t_sum'(1) <<< (FRAC_W - 1);

    logic                    r_vld3;
    logic                    r_vld4;
    logic signed [MUL_W-1:0] r_m [3][3];
    t_sum                    r_sum [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_valid;
            r_vld4 <= r_vld3;
        end
    end

    // Nine coefficient by component products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m[i][j] <= MUL_W'(i_k[i][j]) * MUL_W'(i_v[j]);
                end
            end
        end
    end

    // Row sums, with half an output unit added for round-half-up.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= SUM_W'(r_m[i][0]) + SUM_W'(r_m[i][1])
                          + SUM_W'(r_m[i][2]) + HALF;
            end
        end
    end

    assign o_valid = r_vld4;
    assign o_sum   = r_sum;

endmodule

// ===== rtl/core/qvr_sat.sv =====
// Stage five: drop the fraction bits, clamp each component and flag any clamp.
// Depends on qvr_pkg; its registers are the output word of the core.
module qvr_sat (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  qvr_pkg::t_sum      i_sum [3],
    output logic               o_valid,
    output qvr_pkg::t_out_word o_word
);
    import qvr_pkg::*;

    localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(COMP_MAX);
    localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(COMP_MIN);

    logic                    r_vld5;
    t_out_word               r_word;
    t_out_word               n_word;
    logic signed [RND_W-1:0] c_rnd [3];
    t_comp                   c_clip [3];
    logic [2:0]              c_hit;

    // Floor division by the fraction scale is the top slice of the sum.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_rnd[i] = i_sum[i][SUM_W-1:FRAC_W];
            if (c_rnd[i] > RND_MAX) begin
                c_clip[i] = COMP_MAX;
                c_hit[i]  = 1'b1;
            end else if (c_rnd[i] < RND_MIN) begin
                c_clip[i] = COMP_MIN;
                c_hit[i]  = 1'b1;
            end else begin
                c_clip[i] = c_rnd[i][COMP_W-1:0];
                c_hit[i]  = 1'b0;
            end
        end
        n_word.r_x       = c_clip[0];
        n_word.r_y       = c_clip[1];
        n_word.r_z       = c_clip[2];
        n_word.saturated = |c_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else if (i_en) begin
            r_vld5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_vld5;
    assign o_word  = r_word;

endmodule

// ===== rtl/core/quaternion_vector_rotation_top.sv =====
// Quaternion vector rotation core, five register stages.
// Each accepted word passes through the coef, mac and sat stage registers in order to o_valid.
// Throughput: one word per cycle; the whole pipeline holds while the output word is stalled.
// Reset clears every stage valid bit at once; data registers are not reset.
// Depends on qvr_pkg, qvr_coef, qvr_mac, qvr_sat and the assertion macro header.
`include "quaternion_vector_rotation_top_defines.svh"

module quaternion_vector_rotation_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  qvr_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output qvr_pkg::t_out_word o_word
);
    import qvr_pkg::*;

    logic  c_en;
    logic  c_vld2;
    logic  c_vld4;
    t_coef c_k [3][3];
    t_comp c_v [3];
    t_sum  c_sum [3];

    // The pipeline advances unless a finished word waits on a stalled output.
    assign o_stall = o_valid & i_stall;
    assign c_en    = ~o_stall;

    qvr_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_valid (c_vld2),
        .o_k     (c_k),
        .o_v     (c_v)
    );

    qvr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (c_vld2),
        .i_k     (c_k),
        .i_v     (c_v),
        .o_valid (c_vld4),
        .o_sum   (c_sum)
    );

    qvr_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (c_vld4),
        .i_sum   (c_sum),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    // A clamped word must carry at least one component at a range limit.
    `QVR_ASSERT_IMP(a_sat_at_limit, o_valid && o_word.saturated,
        (o_word.r_x == COMP_MAX) || (o_word.r_x == COMP_MIN) ||
        (o_word.r_y == COMP_MAX) || (o_word.r_y == COMP_MIN) ||
        (o_word.r_z == COMP_MAX) || (o_word.r_z == COMP_MIN),
        "saturated flag set with no component at a limit")

    // Upstream is only held back by a word that is actually waiting.
    `QVR_ASSERT_IMP(a_stall_needs_word, o_stall, o_valid,
        "input stalled while no output word is pending")

    // Reset empties the pipeline.
    `QVR_ASSERT_RST(a_reset_empty, !o_valid, "output valid right after reset")

endmodule
